// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands for the prefix evaluator, clocked on clk, held off in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent then consequent on the next edge
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// antecedent and consequent on the same edge
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/pee_pkg.sv =====
// Shared types, constants and codes of the prefix expression evaluator
`default_nettype none

package pee_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int ITER_W      = $clog2(VALUE_WIDTH);

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNDER   = 3'd1;
	localparam logic [2:0] ST_DIVZERO = 3'd2;
	localparam logic [2:0] ST_OVER    = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;

	// token characters
	localparam logic [7:0] TOK_0   = 8'h30;
	localparam logic [7:0] TOK_9   = 8'h39;
	localparam logic [7:0] TOK_ADD = 8'h2b;
	localparam logic [7:0] TOK_SUB = 8'h2d;
	localparam logic [7:0] TOK_MUL = 8'h2a;
	localparam logic [7:0] TOK_DIV = 8'h2f;
	localparam logic [7:0] TOK_POW = 8'h5e;

	typedef struct packed {
		logic [7:0] token;
		logic       last;
	} tok_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic       load_tok;
		logic       push;
		logic       flag_en;
		logic [2:0] flag_code;
		logic       rd;
		logic       setup;
		logic       iter;
		logic       wb;
		logic       emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic digit;
		logic op;
		logic full;
		logic lt2;
		logic empty;
		logic err_ok;
		logic long_op;
		logic iter_done;
		logic last;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pee_datapath.sv =====
// Operand stack, token register, iterative divide/power unit and result register
`default_nettype none

module pee_datapath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire pee_pkg::tok_t  tok,
	input  wire pee_pkg::cmd_t  cmd,
	output pee_pkg::sts_t       sts,
	output pee_pkg::res_t       res
);
	import pee_pkg::*;

	localparam int VW = VALUE_WIDTH;

	logic [VW-1:0]     mem [STACK_DEPTH];
	logic [VW-1:0]     rd_q;
	logic [VW-1:0]     top_q;
	logic [SP_W-1:0]   sp_q;
	logic [2:0]        err_q;
	logic [7:0]        tok_q;
	logic              last_q;

	// iteration registers: acc = result/quotient, aux = base/remainder,
	// shf = exponent/dividend, dvs = divisor
	logic [VW-1:0]     acc_q;
	logic [VW-1:0]     aux_q;
	logic [VW-1:0]     shf_q;
	logic [VW-1:0]     dvs_q;
	logic              div_q;
	logic              neg_q;
	logic [ITER_W-1:0] cnt_q;
	res_t              res_q;

	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [VW-1:0]     m1_x;
	logic [VW-1:0]     m1_y;
	logic [VW-1:0]     m1_p;
	logic [VW-1:0]     m2_p;
	logic [VW:0]       rem_sh;
	logic              rem_ge;
	logic [VW-1:0]     mag_a;
	logic [VW-1:0]     mag_b;
	logic              a_neg;
	logic              b_neg;
	logic              b_zero;
	logic              bad;
	logic [VW-1:0]     pow_neg;
	logic [2:0]        set_code;
	logic              set_en;

	assign wr_addr = ADDR_W'(sp_q - SP_W'(1));
	assign rd_addr = ADDR_W'(sp_q - SP_W'(2));

	assign a_neg  = top_q[VW-1];
	assign b_neg  = rd_q[VW-1];
	assign b_zero = (rd_q == '0);
	assign mag_a  = a_neg ? VW'(-top_q) : top_q;
	assign mag_b  = b_neg ? VW'(-rd_q) : rd_q;

	// one shared multiplier for '*' and the running power product
	assign m1_x = cmd.setup ? top_q : acc_q;
	assign m1_y = cmd.setup ? rd_q : aux_q;
	assign m1_p = VW'(m1_x * m1_y);
	assign m2_p = VW'(aux_q * aux_q);

	assign rem_sh = {aux_q, shf_q[VW-1]};
	assign rem_ge = (rem_sh >= {1'b0, dvs_q});

	// negative exponent: only |a| = 1 survives
	always_comb begin
		if (top_q == VW'(1))
			pow_neg = VW'(1);
		else if (top_q == '1)
			pow_neg = rd_q[0] ? '1 : VW'(1);
		else
			pow_neg = '0;
	end

	assign bad = cmd.setup && (b_zero ? (tok_q == TOK_DIV) :
		(tok_q == TOK_POW && b_neg && top_q == '0));

	always_comb begin
		set_en   = 1'b0;
		set_code = ST_OK;
		if (cmd.flag_en) begin
			set_en   = 1'b1;
			set_code = cmd.flag_code;
		end else if (bad) begin
			set_en   = 1'b1;
			set_code = ST_DIVZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push && sp_q != '0)
			mem[wr_addr] <= top_q;
		if (cmd.rd)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			err_q <= ST_OK;
		end else begin
			if (cmd.emit) begin
				sp_q  <= '0;
				err_q <= ST_OK;
			end else begin
				if (cmd.push)
					sp_q <= sp_q + SP_W'(1);
				else if (cmd.wb)
					sp_q <= sp_q - SP_W'(1);
				if (set_en && err_q == ST_OK)
					err_q <= set_code;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			tok_q  <= tok.token;
			last_q <= tok.last;
		end
		if (cmd.push)
			top_q <= VW'(tok_q[3:0]);
		else if (cmd.wb)
			top_q <= neg_q ? VW'(-acc_q) : acc_q;

		if (cmd.setup) begin
			neg_q <= 1'b0;
			div_q <= 1'b0;
			cnt_q <= '0;
			unique case (tok_q)
				TOK_ADD: acc_q <= VW'(top_q + rd_q);
				TOK_SUB: acc_q <= VW'(top_q - rd_q);
				TOK_MUL: acc_q <= m1_p;
				TOK_DIV: begin
					acc_q <= '0;
					aux_q <= '0;
					shf_q <= mag_a;
					dvs_q <= mag_b;
					div_q <= 1'b1;
					neg_q <= !b_zero && (a_neg != b_neg);
				end
				default: begin
					if (b_neg) begin
						acc_q <= pow_neg;
					end else begin
						acc_q <= VW'(1);
						aux_q <= top_q;
						shf_q <= rd_q;
					end
				end
			endcase
		end else if (cmd.iter) begin
			cnt_q <= cnt_q + ITER_W'(1);
			if (div_q) begin
				shf_q <= {shf_q[VW-2:0], 1'b0};
				aux_q <= rem_ge ? VW'(rem_sh - {1'b0, dvs_q}) : VW'(rem_sh);
				acc_q <= {acc_q[VW-2:0], rem_ge};
			end else begin
				shf_q <= {1'b0, shf_q[VW-1:1]};
				aux_q <= m2_p;
				if (shf_q[0])
					acc_q <= m1_p;
			end
		end

		if (cmd.emit) begin
			res_q.value  <= (sp_q != '0) ? 32'(signed'(top_q)) : '0;
			res_q.status <= (err_q != ST_OK) ? err_q :
				((sp_q == '0) ? ST_EMPTY : ST_OK);
		end
	end

	assign sts.digit     = (tok_q >= TOK_0) && (tok_q <= TOK_9);
	assign sts.op        = (tok_q == TOK_ADD) || (tok_q == TOK_SUB) || (tok_q == TOK_MUL) ||
		(tok_q == TOK_DIV) || (tok_q == TOK_POW);
	assign sts.full      = (sp_q == SP_W'(STACK_DEPTH));
	assign sts.lt2       = (sp_q < SP_W'(2));
	assign sts.empty     = (sp_q == '0);
	assign sts.err_ok    = (err_q == ST_OK);
	assign sts.long_op   = ((tok_q == TOK_DIV) && !b_zero) || ((tok_q == TOK_POW) && !b_neg);
	assign sts.iter_done = (cnt_q == ITER_W'(VALUE_WIDTH - 1));
	assign sts.last      = last_q;

	assign res = res_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pee_ctrl.sv =====
// Sequencer for one token at a time, plus the result valid flag
`default_nettype none

module pee_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 tok_valid,
	output logic                tok_stall,
	output logic                res_valid,
	input  wire                 res_stall,
	input  wire pee_pkg::sts_t  sts,
	output pee_pkg::cmd_t       cmd
);
	import pee_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_ITER   = 3'd3;
	localparam logic [2:0] S_WB     = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign tok_stall = (state_q != S_IDLE);
	assign res_valid = out_valid_q;
	assign slot_free = !out_valid_q || !res_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (tok_valid) begin
					cmd.load_tok = 1'b1;
					state_d      = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = sts.last ? S_EMIT : S_IDLE;
				if (sts.digit) begin
					if (sts.full) begin
						cmd.flag_en   = 1'b1;
						cmd.flag_code = ST_OVER;
					end else begin
						cmd.push = 1'b1;
					end
				end else if (!sts.op) begin
					cmd.flag_en   = 1'b1;
					cmd.flag_code = ST_UNKNOWN;
				end else if (sts.lt2) begin
					cmd.flag_en   = 1'b1;
					cmd.flag_code = ST_UNDER;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.setup = 1'b1;
				state_d   = sts.long_op ? S_ITER : S_WB;
			end
			S_ITER: begin
				cmd.iter = 1'b1;
				if (sts.iter_done)
					state_d = S_WB;
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = sts.last ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!res_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/prefix_expression_evaluator_unit.sv =====
// Top level of the stack-based prefix expression evaluator
//
//   channel  dir  handshake            payload
//   tok      in   tok_valid/tok_stall  token[7:0], last
//   res      out  res_valid/res_stall  value[31:0] signed, status[2:0]
//
// One token at a time; the stall drops again once the token has been applied.
// Digit, unknown token or stack error: decode only. + - *, divide by zero and a
// negative exponent: decode, read and write-back. / by a non-zero divisor and ^
// with a non-negative exponent add the iterate state, one bit per cycle in the shared
// divide/power loop (32 steps). A last token then passes through emit.
// Reset leaves the stack empty and the status clear; no clearing pass.
// A result waiting on res_stall holds only the next last token at emit.
`default_nettype none
`include "assert_macros.svh"

module prefix_expression_evaluator_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 tok_valid,
	output logic                tok_stall,
	input  wire pee_pkg::tok_t  tok,
	output logic                res_valid,
	input  wire                 res_stall,
	output pee_pkg::res_t       res
);
	import pee_pkg::*;

	cmd_t cmd;
	sts_t dp_sts;

	pee_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (dp_sts),
		.cmd       (cmd)
	);

	pee_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.tok    (tok),
		.cmd    (cmd),
		.sts    (dp_sts),
		.res    (res)
	);

	`ASSERT_NEXT(a_busy_after_accept, tok_valid && !tok_stall, tok_stall, "item taken while busy")
	`ASSERT_NEXT(a_clear_after_emit, cmd.emit, dp_sts.empty && dp_sts.err_ok, "stack not cleared")
	`ASSERT_NEXT(a_no_repeat, res_valid && !res_stall && !cmd.emit, !res_valid, "item repeated")
	`ASSERT_SAME(a_emit_slot, cmd.emit, !res_valid || !res_stall, "result overwritten")

endmodule

`default_nettype wire
